// ----- rtl/iee_pkg.sv -----
// ---------------------------------------------------------------------------
// iee_pkg: shared types and constants for the infix expression evaluator.
// Token kinds, operator codes, error codes, command and status types, precedence.
// ---------------------------------------------------------------------------
package iee_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W = $clog2(VALUE_WIDTH + 1);

    // Token kinds.
    localparam logic [2:0] TOK_NUMBER = 3'd0;
    localparam logic [2:0] TOK_OPERATOR = 3'd1;
    localparam logic [2:0] TOK_OPEN = 3'd2;
    localparam logic [2:0] TOK_CLOSE = 3'd3;
    localparam logic [2:0] TOK_END = 3'd4;

    // Operator stack codes.
    localparam logic [2:0] OPC_ADD = 3'd0;
    localparam logic [2:0] OPC_SUB = 3'd1;
    localparam logic [2:0] OPC_MUL = 3'd2;
    localparam logic [2:0] OPC_DIV = 3'd3;
    localparam logic [2:0] OPC_PAREN = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_DIVZERO = 2'd3;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic       latch_token;  // capture the input item
        logic       push_num;     // push the latched number
        logic       push_op;      // push the latched operator code
        logic       push_paren;   // push an open paren marker
        logic       pop_op;       // drop the top operator
        logic       read_op;      // fetch top operator into register
        logic       reduce_rd;    // fetch and pop two top values and pop the operator
        logic       read_top;     // fetch the top value without popping
        logic       reduce_exec;  // start arithmetic on fetched values
        logic       reduce_wb;    // push arithmetic result
        logic       flag_under;   // flag underflow
        logic       load_out;     // capture the result item
        logic       clear;        // clear counts for the next expression
        logic       count_token;  // advance the token counter
    } iee_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] vcount;
        logic [CNT_W-1:0] ocount;
        logic [2:0]       top_op;
        logic [2:0]       action;
        logic [2:0]       tok_op;
        logic             alu_done;
    } iee_status_t;

    function automatic logic [1:0] prec(input logic [2:0] opc);
        logic [1:0] p;
        begin
            case (opc)
                OPC_ADD, OPC_SUB: p = 2'd1;
                OPC_MUL, OPC_DIV: p = 2'd2;
                default: p = 2'd0;
            endcase
            return p;
        end
    endfunction

endpackage

// ----- rtl/infix_expression_evaluator_unit.sv -----
// ---------------------------------------------------------------------------
// infix_expression_evaluator_unit: two-stack infix evaluator.
// Tokens in, one result item for each end-of-line token.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   action, number, operator_code
//   out      output     out_valid / out_stall result_value, tokens_consumed,
//                                             error_code
//
// A number, open paren or separator is pushed or dropped straight from decode.
// An operator, close paren or end token peeks the operator stack and reduces
// while precedence allows; a divide reduction runs one quotient bit a cycle in
// the divider, an operator with too few values is dropped on underflow and each
// unmatched open paren is dropped at end. The end token then emits and clears.
// Reset clears the counts and the error; stacks need no clearing.
// While a result is held under stall, no new item is taken.
// ---------------------------------------------------------------------------
module infix_expression_evaluator_unit
    import iee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         action,
    input  logic signed [31:0] number,
    input  logic [1:0]         operator_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_value,
    output logic [15:0]        tokens_consumed,
    output logic [1:0]         error_code
);

    iee_cmd_t    cmd;
    iee_status_t status;

    iee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    iee_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .action          (action),
        .number          (number),
        .operator_code   (operator_code),
        .status          (status),
        .result_value    (result_value),
        .tokens_consumed (tokens_consumed),
        .error_code      (error_code)
    );

endmodule

// ----- rtl/iee_alu.sv -----
// ---------------------------------------------------------------------------
// iee_alu: arithmetic unit for one reduction.
// Add, subtract and multiply have their result registered in the cycle after
// start; divide is restoring, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module iee_alu
    import iee_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [2:0]             opc,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic                   div_zero,
    output logic [VALUE_WIDTH-1:0] result
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   dz_reg, dz_next;
    logic                   neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;
    logic [VALUE_WIDTH-1:0] mag_a, mag_b;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   shifted;

    assign mag_a = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
    assign mag_b = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;
    assign shifted = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign trial = shifted - {1'b0, dvs_reg};

    // Start, divide step and completion.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        dz_next = dz_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        res_next = res_reg;
        if (start)
        begin
            dz_next = 1'b0;
            case (opc)
                OPC_ADD: begin res_next = a + b; done_next = 1'b1; end
                OPC_SUB: begin res_next = a - b; done_next = 1'b1; end
                OPC_MUL: begin res_next = a * b; done_next = 1'b1; end
                default:
                begin
                    if (b == '0)
                    begin
                        res_next = '0;
                        dz_next = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        neg_next = a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
                        quo_next = mag_a;
                        rem_next = '0;
                        dvs_next = mag_b;
                        cnt_next = DIV_CNT_W'(VALUE_WIDTH);
                    end
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (!trial[VALUE_WIDTH])
            begin
                rem_next = trial[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next = neg_reg ? (~quo_next + 1'b1) : quo_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dz_reg <= dz_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign div_zero = dz_reg;
    assign result = res_reg;

endmodule

// ----- rtl/iee_datapath.sv -----
// ---------------------------------------------------------------------------
// iee_datapath: value and operator stacks, token register, counters and
// the result register.
// ---------------------------------------------------------------------------
module iee_datapath
    import iee_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  iee_cmd_t               cmd,
    input  logic [2:0]             action,
    input  logic signed [31:0]     number,
    input  logic [1:0]             operator_code,
    output iee_status_t            status,
    output logic signed [31:0]     result_value,
    output logic [15:0]            tokens_consumed,
    output logic [1:0]             error_code
);

    logic [VALUE_WIDTH-1:0] vstack [STACK_DEPTH];
    logic [2:0]             ostack [STACK_DEPTH];

    logic [CNT_W-1:0]       vcount_reg, vcount_next;
    logic [CNT_W-1:0]       ocount_reg, ocount_next;
    logic [15:0]            tcount_reg, tcount_next;
    logic [1:0]             err_reg, err_next;
    logic [2:0]             act_reg;
    logic [2:0]             topc_reg;
    logic [VALUE_WIDTH-1:0] num_reg;
    logic [2:0]             top_reg;
    logic [2:0]             redop_reg;
    logic [VALUE_WIDTH-1:0] va_reg, vb_reg;
    logic [31:0]            res_reg;
    logic [15:0]            tok_out_reg;
    logic [1:0]             err_out_reg;
    logic                   alu_done, alu_dz;
    logic [VALUE_WIDTH-1:0] alu_res;
    logic [SP_W-1:0]        vtop_idx, vsec_idx, otop_idx;
    logic                   v_full, o_full;
    logic                   push_v;
    logic [VALUE_WIDTH-1:0] push_v_data;
    logic                   push_o;
    logic [2:0]             push_o_data;
    logic [1:0]             flag_code;
    logic                   flag_en;

    assign v_full = (vcount_reg == CNT_W'(STACK_DEPTH));
    assign o_full = (ocount_reg == CNT_W'(STACK_DEPTH));
    assign vtop_idx = SP_W'(vcount_reg - 1'b1);
    assign vsec_idx = SP_W'(vcount_reg - 2'd2);
    assign otop_idx = SP_W'(ocount_reg - 1'b1);

    iee_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.reduce_exec),
        .opc      (redop_reg),
        .a        (va_reg),
        .b        (vb_reg),
        .done     (alu_done),
        .div_zero (alu_dz),
        .result   (alu_res)
    );

    // Push selection and error flagging.
    always_comb
    begin
        push_v = cmd.push_num | cmd.reduce_wb;
        push_v_data = cmd.reduce_wb ? alu_res : num_reg;
        push_o = cmd.push_op | cmd.push_paren;
        push_o_data = cmd.push_paren ? OPC_PAREN : topc_reg;
        flag_en = 1'b0;
        flag_code = ERR_NONE;
        if (cmd.reduce_wb && alu_dz)
        begin
            flag_en = 1'b1;
            flag_code = ERR_DIVZERO;
        end
        else if ((push_v && v_full) || (push_o && o_full))
        begin
            flag_en = 1'b1;
            flag_code = ERR_OVERFLOW;
        end
        else if (cmd.flag_under)
        begin
            flag_en = 1'b1;
            flag_code = ERR_UNDERFLOW;
        end
    end

    // Counter updates.
    always_comb
    begin
        vcount_next = vcount_reg;
        ocount_next = ocount_reg;
        tcount_next = tcount_reg;
        err_next = err_reg;
        if (flag_en && err_reg == ERR_NONE)
            err_next = flag_code;
        // A divide by zero push still succeeds unless full; flag order keeps first.
        if (cmd.reduce_wb && alu_dz && v_full && err_reg == ERR_NONE)
            err_next = ERR_DIVZERO;
        if (cmd.reduce_rd)
        begin
            ocount_next = ocount_reg - 1'b1;
            vcount_next = vcount_reg - 2'd2;
        end
        if (cmd.pop_op)
            ocount_next = ocount_reg - 1'b1;
        if (push_v && !v_full)
            vcount_next = vcount_reg + 1'b1;
        if (push_o && !o_full)
            ocount_next = ocount_reg + 1'b1;
        if (cmd.count_token && tcount_reg != 16'hFFFF)
            tcount_next = tcount_reg + 1'b1;
        if (cmd.clear)
        begin
            vcount_next = '0;
            ocount_next = '0;
            tcount_next = '0;
            err_next = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            ocount_reg <= '0;
            tcount_reg <= '0;
            err_reg <= ERR_NONE;
        end
        else
        begin
            vcount_reg <= vcount_next;
            ocount_reg <= ocount_next;
            tcount_reg <= tcount_next;
            err_reg <= err_next;
        end
    end

    // Stack memories and operand fetch.
    always_ff @(posedge clk)
    begin
        if (push_v && !v_full)
            vstack[vcount_reg[SP_W-1:0]] <= push_v_data;
        if (push_o && !o_full)
            ostack[ocount_reg[SP_W-1:0]] <= push_o_data;
        if (cmd.read_op)
            top_reg <= ostack[otop_idx];
        if (cmd.reduce_rd || cmd.read_top)
            vb_reg <= vstack[vtop_idx];
        if (cmd.reduce_rd)
        begin
            va_reg <= vstack[vsec_idx];
            redop_reg <= top_reg;
        end
        if (cmd.latch_token)
        begin
            act_reg <= action;
            num_reg <= VALUE_WIDTH'(number);
            topc_reg <= {1'b0, operator_code};
        end
        if (cmd.load_out)
        begin
            res_reg <= (err_next != ERR_NONE || vcount_reg == '0) ? 32'd0
                       : 32'(vb_reg);
            tok_out_reg <= tcount_reg;
            err_out_reg <= err_next;
        end
    end

    assign status.vcount = vcount_reg;
    assign status.ocount = ocount_reg;
    assign status.top_op = top_reg;
    assign status.action = act_reg;
    assign status.tok_op = topc_reg;
    assign status.alu_done = alu_done;

    assign result_value = res_reg;
    assign tokens_consumed = tok_out_reg;
    assign error_code = err_out_reg;

endmodule

// ----- rtl/iee_ctrl.sv -----
// ---------------------------------------------------------------------------
// iee_ctrl: token sequencer. Decides pushes, reductions and the end-of-line
// drain, and drives both handshakes.
// ---------------------------------------------------------------------------
module iee_ctrl
    import iee_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  iee_status_t status,
    output iee_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_PEEK = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_EXEC = 4'd4;
    localparam logic [3:0] S_WAIT = 4'd5;
    localparam logic [3:0] S_WB = 4'd6;
    localparam logic [3:0] S_FETCH = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;
    localparam logic [3:0] S_CLEAR = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       accept;
    logic       is_end, is_op, is_close;

    assign is_end = (status.action == TOK_END);
    assign is_op = (status.action == TOK_OPERATOR);
    assign is_close = (status.action == TOK_CLOSE);

    // The next item enters once the current one is finished and any prior
    // result has room to be held.
    assign in_stall = (state_reg != S_IDLE) || (ovalid_reg && out_stall);
    assign accept = in_valid && !in_stall;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch_token = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.action)
                    TOK_NUMBER:
                    begin
                        cmd.push_num = 1'b1;
                        cmd.count_token = 1'b1;
                        state_next = S_IDLE;
                    end
                    TOK_OPEN:
                    begin
                        cmd.push_paren = 1'b1;
                        cmd.count_token = 1'b1;
                        state_next = S_IDLE;
                    end
                    TOK_OPERATOR, TOK_CLOSE, TOK_END: state_next = S_PEEK;
                    default:
                    begin
                        cmd.count_token = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PEEK:
            begin
                if (status.ocount != '0)
                begin
                    cmd.read_op = 1'b1;
                    state_next = S_CHECK;
                end
                else
                    state_next = S_FETCH;
            end
            S_CHECK:
            begin
                // Top operator is in register; decide to reduce, drop an open paren or stop.
                if (is_op)
                begin
                    if (status.top_op != OPC_PAREN &&
                        prec(status.top_op) >= prec(status.tok_op))
                        state_next = S_EXEC;
                    else
                        state_next = S_FETCH;
                end
                else if (status.top_op == OPC_PAREN)
                begin
                    cmd.pop_op = 1'b1;
                    state_next = is_close ? S_FETCH : S_PEEK;
                end
                else
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (status.vcount < CNT_W'(2))
                begin
                    cmd.pop_op = 1'b1;
                    cmd.flag_under = 1'b1;
                    state_next = S_PEEK;
                end
                else
                begin
                    cmd.reduce_rd = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                cmd.reduce_exec = 1'b1;
                state_next = S_WB;
            end
            S_WB:
            begin
                if (status.alu_done)
                begin
                    cmd.reduce_wb = 1'b1;
                    state_next = S_PEEK;
                end
            end
            S_FETCH:
            begin
                // Finish the token once no more reductions apply.
                if (is_op)
                begin
                    cmd.push_op = 1'b1;
                    cmd.count_token = 1'b1;
                    state_next = S_IDLE;
                end
                else if (is_close)
                begin
                    cmd.count_token = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Fetch top value into operand b via a read with no pop.
                    cmd.read_top = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.load_out = 1'b1;
                cmd.flag_under = (status.vcount == '0);
                ovalid_next = 1'b1;
                state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ----- rtl/iee_checker.sv -----
// ---------------------------------------------------------------------------
// iee_checker: port-level checks for the evaluator.
// Watches the handshakes and result fields over time.
// ---------------------------------------------------------------------------
module iee_checker
    import iee_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] result_value,
    input  logic [1:0]         error_code
);

    // A result held under stall keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value))
        else $error("result changed while stalled");

    // An errored result carries the value zero.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> result_value == 32'sd0)
        else $error("nonzero value with error");

    // Accepting an item never coincides with a new result in the next cycle.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    // After accepting an item the block stalls its input in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken on consecutive cycles");

endmodule

bind infix_expression_evaluator_unit iee_checker u_iee_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .error_code   (error_code)
);

// ----- tb/infix_expression_evaluator_unit_tb.sv -----
// ---------------------------------------------------------------------------
// infix_expression_evaluator_unit_tb: self-checking bench for the evaluator.
// Walks a directed table, then overflow runs and random expressions. Each end
// token yields one expected result, computed by a two-stack model in the bench.
// ---------------------------------------------------------------------------
module infix_expression_evaluator_unit_tb;
    import iee_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] value;
        logic [15:0]        tokens;
        logic [1:0]         err;
    } expr_result_t;

    typedef struct {
        logic [2:0]         act;
        logic signed [31:0] num;
        logic [1:0]         opc;
        bit                 has_fixed;
        expr_result_t       fixed;
    } token_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         action;
    logic signed [31:0] number;
    logic [1:0]         operator_code;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_value;
    logic [15:0]        tokens_consumed;
    logic [1:0]         error_code;

    // Bench copy of the evaluator state.
    logic [31:0] vals[STACK_DEPTH];
    int          vcnt;
    logic [2:0]  ops[STACK_DEPTH];
    int          ocnt;
    int          tok_cnt;
    logic [1:0]  sticky;

    expr_result_t pending_results[$];
    token_row_t   token_table[$];
    int           fail_count;
    int           idle_cycles;
    int           items_sent;
    bit           stim_done;
    bit           long_holdoff;

    infix_expression_evaluator_unit i_dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int op_rank(input logic [2:0] opc);
        if (opc == OPC_ADD || opc == OPC_SUB) return 1;
        if (opc == OPC_MUL || opc == OPC_DIV) return 2;
        return 0;
    endfunction

    function automatic void raise_error(input logic [1:0] code);
        if (sticky == ERR_NONE) sticky = code;
    endfunction

    function automatic void push_val(input logic [31:0] v);
        if (vcnt >= STACK_DEPTH) raise_error(ERR_OVERFLOW);
        else
        begin
            vals[vcnt] = v;
            vcnt++;
        end
    endfunction

    function automatic void push_op(input logic [2:0] opc);
        if (ocnt >= STACK_DEPTH) raise_error(ERR_OVERFLOW);
        else
        begin
            ops[ocnt] = opc;
            ocnt++;
        end
    endfunction

    function automatic logic [31:0] apply_op(input logic [31:0] a, input logic [31:0] b,
                                             input logic [2:0] opc);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        case (opc)
            OPC_ADD: return a + b;
            OPC_SUB: return a - b;
            OPC_MUL: return a * b;
            default: ;
        endcase
        if (b == 0)
        begin
            raise_error(ERR_DIVZERO);
            return 0;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic void reduce_once();
        logic [2:0] opc;
        logic [31:0] a;
        logic [31:0] b;
        ocnt--;
        opc = ops[ocnt];
        if (vcnt < 2)
        begin
            raise_error(ERR_UNDERFLOW);
            return;
        end
        b = vals[vcnt-1];
        a = vals[vcnt-2];
        vcnt -= 2;
        push_val(apply_op(a, b, opc));
    endfunction

    function automatic void clear_model();
        vcnt = 0;
        ocnt = 0;
        tok_cnt = 0;
        sticky = ERR_NONE;
    endfunction

    // Advances the model by one token; returns 1 with the result on an end token.
    function automatic bit eval_token(input logic [2:0] act, input logic [31:0] num,
                                      input logic [1:0] opc, output expr_result_t res);
        logic [31:0] v;
        res = '0;
        if (act == TOK_END)
        begin
            v = 0;
            while (ocnt > 0)
            begin
                if (ops[ocnt-1] == OPC_PAREN) ocnt--;
                else reduce_once();
            end
            if (vcnt == 0) raise_error(ERR_UNDERFLOW);
            else v = vals[vcnt-1];
            if (sticky != ERR_NONE) v = 0;
            res.value = v;
            res.tokens = tok_cnt[15:0];
            res.err = sticky;
            clear_model();
            return 1;
        end
        if (act == TOK_NUMBER) push_val(num);
        else if (act == TOK_OPERATOR)
        begin
            while (ocnt > 0 && op_rank(ops[ocnt-1]) >= op_rank({1'b0, opc}))
                reduce_once();
            push_op({1'b0, opc});
        end
        else if (act == TOK_OPEN) push_op(OPC_PAREN);
        else if (act == TOK_CLOSE)
        begin
            while (ocnt > 0 && ops[ocnt-1] != OPC_PAREN) reduce_once();
            if (ocnt > 0) ocnt--;
        end
        if (tok_cnt < 16'hFFFF) tok_cnt++;
        return 0;
    endfunction

    // Sends one item after a random gap and records any expected result.
    task automatic send_token(input logic [2:0] act, input logic [31:0] num,
                              input logic [1:0] opc, input bit has_fixed,
                              input expr_result_t fixed);
        int gap;
        expr_result_t res;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        number <= num;
        operator_code <= opc;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (eval_token(act, num, opc, res))
        begin
            if (has_fixed && res !== fixed)
            begin
                $error("table row disagrees with model: expected %h, model %h", fixed, res);
                fail_count++;
            end
            pending_results.push_back(res);
        end
    endtask

    task automatic add_row(input logic [2:0] act, input logic [31:0] num,
                           input logic [1:0] opc);
        token_row_t r;
        r.act = act;
        r.num = num;
        r.opc = opc;
        r.has_fixed = 0;
        r.fixed = '0;
        token_table.push_back(r);
    endtask

    task automatic add_end(input bit has_fixed, input logic [31:0] v,
                           input int n, input logic [1:0] e);
        token_row_t r;
        r.act = TOK_END;
        r.num = $urandom;
        r.opc = 2'($urandom);
        r.has_fixed = has_fixed;
        r.fixed.value = v;
        r.fixed.tokens = n[15:0];
        r.fixed.err = e;
        token_table.push_back(r);
    endtask

    // Random well-formed expression, optionally broken, then an end token.
    task automatic send_expression();
        int terms;
        int depth;
        int roll;
        int i;
        terms = ($urandom_range(0, 30) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        depth = 0;
        for (i = 0; i < terms; i++)
        begin
            if (i > 0)
            begin
                if (depth > 0 && $urandom_range(0, 4) == 0)
                begin
                    send_token(TOK_CLOSE, $urandom, 2'($urandom), 0, '0);
                    depth--;
                end
                send_token(TOK_OPERATOR, $urandom, 2'($urandom), 0, '0);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                send_token(TOK_OPEN, $urandom, 2'($urandom), 0, '0);
                depth++;
            end
            roll = $urandom_range(0, 9);
            send_token(TOK_NUMBER,
                       roll < 5 ? $urandom_range(0, 20) - 5 :
                       roll < 7 ? 0 : roll == 7 ? 32'h80000000 : $urandom,
                       2'($urandom), 0, '0);
            // Occasional noise: separators, stray tokens, unknown kinds.
            if ($urandom_range(0, 9) == 0)
                send_token($urandom_range(1, 7) == 4 ? 3'd5 : $urandom_range(0, 7) == 4 ? 3'd5
                           : 3'($urandom_range(0, 7)) == TOK_END ? 3'd5 : 3'($urandom_range(0, 7)),
                           $urandom, 2'($urandom), 0, '0);
        end
        while (depth > 0 && $urandom_range(0, 2) != 0)
        begin
            send_token(TOK_CLOSE, $urandom, 2'($urandom), 0, '0);
            depth--;
        end
        send_token(TOK_END, $urandom, 2'($urandom), 0, '0);
    endtask

    // Stimulus: directed table, a long stall phase, then random expressions.
    initial
    begin
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        number = '0;
        operator_code = '0;
        fail_count = 0;
        items_sent = 0;
        stim_done = 0;
        long_holdoff = 0;
        clear_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End with nothing: underflow after reset.
        add_end(1, 0, 0, ERR_UNDERFLOW);
        // 7 / 0 gives divide by zero.
        add_row(TOK_NUMBER, 7, 0);
        add_row(TOK_OPERATOR, 0, 2'(OPC_DIV));
        add_row(TOK_NUMBER, 0, 0);
        add_end(1, 0, 3, ERR_DIVZERO);
        // Most negative over minus one wraps.
        add_row(TOK_NUMBER, 32'h80000000, 0);
        add_row(TOK_OPERATOR, 0, 2'(OPC_DIV));
        add_row(TOK_NUMBER, 32'hFFFFFFFF, 0);
        add_end(1, 32'h80000000, 3, ERR_NONE);
        // Extremes: max plus one wraps.
        add_row(TOK_NUMBER, 32'h7FFFFFFF, 0);
        add_row(TOK_OPERATOR, 0, 2'(OPC_ADD));
        add_row(TOK_NUMBER, 1, 0);
        add_end(1, 32'h80000000, 3, ERR_NONE);
        // (2 - 9) * -3 with a separator, an unknown kind and an unmatched open paren.
        add_row(TOK_OPEN, 0, 0);
        add_row(TOK_OPEN, 0, 0);
        add_row(TOK_NUMBER, 2, 0);
        add_row(TOK_OPERATOR, 0, 2'(OPC_SUB));
        add_row(TOK_NUMBER, 9, 0);
        add_row(TOK_CLOSE, 0, 0);
        add_row(3'd5, 0, 0);
        add_row(TOK_OPERATOR, 0, 2'(OPC_MUL));
        add_row(TOK_NUMBER, -3, 0);
        add_row(3'd7, 0, 0);
        add_end(0, 0, 0, 0);
        // Operator with one value: underflow; extra values; unmatched close.
        add_row(TOK_NUMBER, 5, 0);
        add_row(TOK_OPERATOR, 0, 2'(OPC_ADD));
        add_row(TOK_CLOSE, 0, 0);
        add_row(TOK_NUMBER, 4, 0);
        add_row(3'd6, 0, 0);
        add_end(0, 0, 0, 0);
        foreach (token_table[k])
            send_token(token_table[k].act, token_table[k].num, token_table[k].opc,
                       token_table[k].has_fixed, token_table[k].fixed);

        // Overflow: 34 pushes of numbers while the receiver holds off.
        long_holdoff = 1;
        for (i = 0; i < 34; i++) send_token(TOK_NUMBER, i, 0, 0, '0);
        send_token(TOK_END, 0, 0, 0, '0);
        // Operator stack overflow through open parens.
        for (i = 0; i < 34; i++) send_token(TOK_OPEN, 0, 0, 0, '0);
        send_token(TOK_END, 0, 0, 0, '0);
        for (i = 0; i < 6; i++)
            send_expression();
        long_holdoff = 0;

        while (items_sent < 1900)
            send_expression();
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls, with a long hold-off during the fill phase.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_holdoff)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                out_stall <= 1'b0;
                while (long_holdoff) @(posedge clk);
            end
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            out_stall <= (hold > 0);
            repeat (hold) @(posedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        expr_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with none expected: value %0d", result_value);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %0d, got %0d", want.value, result_value);
                    fail_count++;
                end
                if (tokens_consumed !== want.tokens)
                begin
                    $error("tokens_consumed: expected %0d, got %0d", want.tokens,
                           tokens_consumed);
                    fail_count++;
                end
                if (error_code !== want.err)
                begin
                    $error("error_code: expected %0d, got %0d", want.err, error_code);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Finish once the stimulus is done and every result has come back.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
            if (stim_done && pending_results.size() == 0)
            begin
                repeat (50) @(posedge clk);
                if (fail_count == 0)
                    $display("PASSED: all results match");
                else
                    $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule
